### sv/uf_pkg.sv
package uf_pkg;

   localparam int unsigned RANK_W = 4;
   localparam logic [RANK_W-1:0] RANK_MAX = 4'd15;

   localparam logic ACT_UNITE = 1'b0;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_WALK,
      ST_FIX,
      ST_LINK,
      ST_BUMP,
      ST_RESP
   } uf_state_type;

endpackage

### sv/union_find_engine.sv
// Disjoint-set engine over NODES nodes using union by rank with path compression. Each
// request beat either unites the sets of two nodes or only asks whether they share a set,
// and every request beat gives one response beat whose same_set flag tells whether both
// nodes had the same root before the request. A node index of NODES or more makes the
// request a no-op that answers 0. Parent and rank live together in one memory with one write
// port and one registered read port, and every pointer hop costs one memory read. A request
// walks from each node to its root and points every node on that path at the root, then
// links the two roots on a unite, with one more rank-raising write when it links two roots of
// equal rank. The memory walk is the limit, and one request is worked on at a time. After
// reset, a clearing pass sets every node to its own root with rank zero, and no request is
// taken until it ends.
module union_find_engine #(
   parameter int unsigned NODES = 1024
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic       req_action,
   input  logic [9:0] req_node_a,
   input  logic [9:0] req_node_b,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic       rsp_same_set
);
   import uf_pkg::*;

   localparam int unsigned IDX_W = $clog2(NODES);
   localparam int unsigned ENT_W = IDX_W + RANK_W;
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NODES - 1);

   logic [ENT_W-1:0] mem [NODES];

   uf_state_type state_ff, state_in;
   logic [IDX_W-1:0] clr_ff, clr_in;
   logic act_ff, act_in;
   logic [IDX_W-1:0] node_b_ff, node_b_in;
   logic phase_ff, phase_in;
   logic [IDX_W-1:0] start_ff, start_in;
   logic [IDX_W-1:0] cur_ff, cur_in;
   logic [IDX_W-1:0] root_ff, root_in;
   logic [IDX_W-1:0] root_a_ff, root_a_in;
   logic [RANK_W-1:0] rank_a_ff, rank_a_in;
   logic [RANK_W-1:0] rank_b_ff, rank_b_in;
   logic same_ff, same_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic rsp_same_set_ff, rsp_same_set_in;

   logic [ENT_W-1:0] rd_data_ff;
   logic [IDX_W-1:0] rd_addr;
   logic wr_en;
   logic [IDX_W-1:0] wr_addr;
   logic [ENT_W-1:0] wr_data;

   logic [IDX_W-1:0] rd_parent;
   logic [RANK_W-1:0] rd_rank;
   logic in_range;
   logic [IDX_W-1:0] node_a_idx;

   assign rd_parent = rd_data_ff[IDX_W-1:0];
   assign rd_rank = rd_data_ff[IDX_W +: RANK_W];
   assign node_a_idx = IDX_W'(req_node_a);
   assign in_range = (32'(req_node_a) < NODES) && (32'(req_node_b) < NODES);

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_same_set = rsp_same_set_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         clr_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         clr_ff <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      act_ff <= act_in;
      node_b_ff <= node_b_in;
      phase_ff <= phase_in;
      start_ff <= start_in;
      cur_ff <= cur_in;
      root_ff <= root_in;
      root_a_ff <= root_a_in;
      rank_a_ff <= rank_a_in;
      rank_b_ff <= rank_b_in;
      same_ff <= same_in;
      rsp_same_set_ff <= rsp_same_set_in;
   end

   always_comb begin
      state_in = state_ff;
      clr_in = clr_ff;
      act_in = act_ff;
      node_b_in = node_b_ff;
      phase_in = phase_ff;
      start_in = start_ff;
      cur_in = cur_ff;
      root_in = root_ff;
      root_a_in = root_a_ff;
      rank_a_in = rank_a_ff;
      rank_b_in = rank_b_ff;
      same_in = same_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_same_set_in = rsp_same_set_ff;
      rd_addr = cur_ff;
      wr_en = 1'b0;
      wr_addr = cur_ff;
      wr_data = {rd_rank, root_ff};

      unique case (state_ff)
         ST_CLEAR: begin
            wr_en = 1'b1;
            wr_addr = clr_ff;
            wr_data = {RANK_W'(0), clr_ff};
            clr_in = clr_ff + IDX_W'(1);
            if (clr_ff == LAST_IDX) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_valid) begin
               act_in = req_action;
               node_b_in = IDX_W'(req_node_b);
               start_in = node_a_idx;
               cur_in = node_a_idx;
               rd_addr = node_a_idx;
               phase_in = 1'b0;
               if (in_range) begin
                  state_in = ST_WALK;
               end else begin
                  same_in = 1'b0;
                  state_in = ST_RESP;
               end
            end
         end
         ST_WALK: begin
            if (rd_parent == cur_ff) begin
               root_in = cur_ff;
               if (!phase_ff) begin
                  root_a_in = cur_ff;
                  rank_a_in = rd_rank;
               end else begin
                  rank_b_in = rd_rank;
               end
               if (start_ff != cur_ff) begin
                  cur_in = start_ff;
                  rd_addr = start_ff;
                  state_in = ST_FIX;
               end else if (!phase_ff) begin
                  phase_in = 1'b1;
                  start_in = node_b_ff;
                  cur_in = node_b_ff;
                  rd_addr = node_b_ff;
               end else begin
                  state_in = ST_LINK;
               end
            end else begin
               cur_in = rd_parent;
               rd_addr = rd_parent;
            end
         end
         ST_FIX: begin
            wr_en = 1'b1;
            wr_addr = cur_ff;
            wr_data = {rd_rank, root_ff};
            if (rd_parent != root_ff) begin
               cur_in = rd_parent;
               rd_addr = rd_parent;
            end else if (!phase_ff) begin
               phase_in = 1'b1;
               start_in = node_b_ff;
               cur_in = node_b_ff;
               rd_addr = node_b_ff;
               state_in = ST_WALK;
            end else begin
               state_in = ST_LINK;
            end
         end
         ST_LINK: begin
            same_in = (root_a_ff == root_ff);
            state_in = ST_RESP;
            if ((act_ff == ACT_UNITE) && (root_a_ff != root_ff)) begin
               wr_en = 1'b1;
               if (rank_a_ff > rank_b_ff) begin
                  wr_addr = root_ff;
                  wr_data = {rank_b_ff, root_a_ff};
               end else begin
                  wr_addr = root_a_ff;
                  wr_data = {rank_a_ff, root_ff};
                  if (rank_a_ff == rank_b_ff) begin
                     state_in = ST_BUMP;
                  end
               end
            end
         end
         ST_BUMP: begin
            wr_en = 1'b1;
            wr_addr = root_ff;
            if (rank_b_ff == RANK_MAX) begin
               wr_data = {rank_b_ff, root_ff};
            end else begin
               wr_data = {rank_b_ff + RANK_W'(1), root_ff};
            end
            state_in = ST_RESP;
         end
         ST_RESP: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               rsp_same_set_in = same_ff;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule
